/* sv/lab2lch_pkg.sv */
// Shared types and constants for the Lab to LCh polar conversion block.
// No dependencies.
`default_nettype none

package lab2lch_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int TABLE_LEN         = 24;

    // Angle accumulator: signed degrees times 2^16
    localparam int ZW = 27;
    localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [ZW-1:0] DEG360 = 27'sd23592960;

    // Gain compensation, 1/K in unsigned Q0.24
    localparam int          INV_GAIN_BITS = 24;
    localparam logic [23:0] INV_GAIN      = 24'd10188014;

    // Hue output: degrees times 128
    localparam int          HUE_SHIFT = 9;
    localparam int          HW        = ZW - HUE_SHIFT;
    localparam logic [ZW-1:0] HUE_HALF = 27'd256;
    localparam logic [HW-1:0] HUE_FULL = 18'd46080;

    typedef struct packed {
        logic        [15:0] lightness;
        logic signed [15:0] axis_a;
        logic signed [15:0] axis_b;
    } t_lch_in;

    typedef struct packed {
        logic [15:0] lightness_out;
        logic [15:0] chroma;
        logic [15:0] hue;
    } t_lch_out;

    // atan(2^-i) in degrees times 2^16, rounded to nearest
    function automatic logic [21:0] atan_deg(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/lab_to_lch_polar_conversion_top.sv */
// Lab to LCh polar conversion: pipelined CORDIC vectoring unit, one request per cycle.
// Registers in order: entry register, one register per CORDIC micro-rotation,
// gain multiply / hue wrap, output register.
// Throughput is one request per clock while results are taken. Once a result waits, the
// skid register behind the output register takes one more; then the whole pipeline
// freezes and o_in_ready stays low until the skid register has drained.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Depends on lab2lch_pkg.
`default_nettype none

module lab_to_lch_polar_conversion_top
    import lab2lch_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,  // 8..24
    parameter int FRAC_BITS     = FRAC_BITS_DEF       // 4..16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // request side
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_lch_in  i_in_data,
    // result side
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_lch_out      o_out_data
);

    localparam int N   = CORDIC_STAGES;
    // x/y datapath: |x| grows to about 1.65 * sqrt(2) * 2^15 * 2^FRAC_BITS
    localparam int XW  = FRAC_BITS + 19;
    localparam int HIW = XW - 17;                  // upper slice of |x| for the split multiply
    localparam int PHW = HIW + INV_GAIN_BITS;
    localparam int PLW = 16 + INV_GAIN_BITS;
    localparam int PW  = XW - 1 + INV_GAIN_BITS;   // full product width
    localparam int SH  = INV_GAIN_BITS + FRAC_BITS;
    localparam int CW  = PW - SH;                  // chroma before saturation

    // ------------------------------------------------------------------
    // Flow control: whole pipeline advances unless the skid register is
    // occupied. Bubbles travel as cleared valid bits.
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic r_out_v;
    logic en;

    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // ------------------------------------------------------------------
    // CORDIC stage registers. Index 0 is the entry register (after the
    // pre-rotation into the right half plane); index k+1 holds the vector
    // after micro-rotation k.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r_x    [0:N];
    logic signed [XW-1:0] r_y    [0:N];
    logic signed [ZW-1:0] r_z    [0:N];
    logic [15:0]          r_l    [0:N];
    logic                 r_zero [0:N];
    logic                 r_v    [0:N];

    logic signed [XW-1:0] n_x    [0:N];
    logic signed [XW-1:0] n_y    [0:N];
    logic signed [ZW-1:0] n_z    [0:N];

    logic signed [XW-1:0] a_w;
    logic signed [XW-1:0] b_w;
    logic                 n_zero0;

    // Pre-rotation: a negative first axis flips the vector by 180 degrees,
    // then one micro-rotation per stage; shifts are arithmetic (floor)
    always_comb begin
        a_w     = XW'(i_in_data.axis_a);
        b_w     = XW'(i_in_data.axis_b);
        n_zero0 = (i_in_data.axis_a == 16'sd0) && (i_in_data.axis_b == 16'sd0);
        if (i_in_data.axis_a[15]) begin
            n_x[0] = (-a_w) <<< FRAC_BITS;
            n_y[0] = (-b_w) <<< FRAC_BITS;
            n_z[0] = DEG180;
        end else begin
            n_x[0] = a_w <<< FRAC_BITS;
            n_y[0] = b_w <<< FRAC_BITS;
            n_z[0] = '0;
        end
        for (int k = 0; k < N; k++) begin
            if (!r_y[k][XW-1]) begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + signed'(ZW'(atan_deg(5'(k))));
            end else begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - signed'(ZW'(atan_deg(5'(k))));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int k = 0; k < N; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= n_x[0];
            r_y[0]    <= n_y[0];
            r_z[0]    <= n_z[0];
            r_l[0]    <= i_in_data.lightness;
            r_zero[0] <= n_zero0;
            for (int k = 0; k < N; k++) begin
                r_x[k+1]    <= n_x[k+1];
                r_y[k+1]    <= n_y[k+1];
                r_z[k+1]    <= n_z[k+1];
                r_l[k+1]    <= r_l[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Post stage: gain multiply split into two partial products, hue wrap
    // into [0,360) and rounding to 1/128 degree.
    // ------------------------------------------------------------------
    logic [XW-2:0]  x_mag;
    logic           x_pos;
    logic [ZW-1:0]  z_wrap;
    logic [ZW-1:0]  h_sum;
    logic [HW-1:0]  h_raw;
    logic [15:0]    n_hue;
    logic [PLW-1:0] n_p_lo;
    logic [PHW-1:0] n_p_hi;

    logic           r_pv;
    logic [PLW-1:0] r_p_lo;
    logic [PHW-1:0] r_p_hi;
    logic [15:0]    r_p_hue;
    logic [15:0]    r_p_l;

    always_comb begin
        x_pos  = !r_x[N][XW-1] && (r_x[N] != '0);
        x_mag  = x_pos ? r_x[N][XW-2:0] : '0;
        n_p_lo = PLW'(x_mag[15:0]) * PLW'(INV_GAIN);
        n_p_hi = PHW'(x_mag[XW-2:16]) * PHW'(INV_GAIN);

        z_wrap = r_z[N][ZW-1] ? unsigned'(r_z[N] + DEG360) : unsigned'(r_z[N]);
        h_sum  = z_wrap + HUE_HALF;
        h_raw  = h_sum[ZW-1:HUE_SHIFT];
        if (h_raw >= HUE_FULL) begin
            h_raw = h_raw - HUE_FULL;
        end
        // both axes zero: hue defined as 0
        n_hue = r_zero[N] ? 16'd0 : h_raw[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_lo  <= n_p_lo;
            r_p_hi  <= n_p_hi;
            r_p_hue <= n_hue;
            r_p_l   <= r_l[N];
        end
    end

    // ------------------------------------------------------------------
    // Final add of the partial products, rounding and saturation, then
    // output register with skid register behind it.
    // ------------------------------------------------------------------
    logic [PW-1:0] prod_sum;
    logic [CW-1:0] c_full;
    t_lch_out      n_out;

    always_comb begin
        prod_sum = (PW'(r_p_hi) << 16) + PW'(r_p_lo) + (PW'(1) << (SH - 1));
        c_full   = CW'(prod_sum >> SH);
        n_out.lightness_out = r_p_l;
        n_out.chroma        = (c_full[CW-1:16] != '0) ? 16'hFFFF : c_full[15:0];
        n_out.hue           = r_p_hue;
    end

    t_lch_out r_out;
    t_lch_out r_skid;
    logic     push;
    logic     take;

    assign push = en && r_pv;
    assign take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (r_out_v && !take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_v && !take) begin
                r_skid <= n_out;
            end else begin
                r_out <= n_out;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
